// File: rtl/xtea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA package
// Shared constants, types and helper functions for the XTEA cipher pipeline.
// ----------------------------------------------------------------------------
package xtea_pkg;

	localparam int unsigned ROUND_COUNT = 32;              // 1 .. 64
	localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT; // one half-round per stage
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned KEY_WORDS   = 4;
	localparam int unsigned KEY_IDX_W   = 2;

	localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

	// one beat as it travels down the pipeline
	typedef struct packed {
		logic  valid;
		logic  op;
		word_t lo;
		word_t hi;
	} stage_t;

	typedef struct packed {
		word_t lo;
		word_t hi;
	} res_t;

	// buffer status towards the pipeline and the output port
	typedef struct packed {
		logic valid;
		logic space;
	} buf_stat_t;

	function automatic word_t mix(input word_t v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

	// running sum used by stage j when encrypting
	function automatic word_t stage_sum_enc(input int unsigned j);
		word_t n;
		n = WORD_W'((j >> 1) + (j & 1));
		return n * DELTA;
	endfunction

	// running sum used by stage j when decrypting
	function automatic word_t stage_sum_dec(input int unsigned j);
		word_t n;
		n = WORD_W'(ROUND_COUNT - (j >> 1) - (j & 1));
		return n * DELTA;
	endfunction

endpackage
`default_nettype wire

// File: rtl/xtea_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA stream interfaces
// Block channel in, result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface xtea_blk_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] block_low;
	logic [31:0] block_high;

	modport source (output valid, output operation, output block_low, output block_high,
		input ready);
	modport sink (input valid, input operation, input block_low, input block_high,
		output ready);
endinterface

interface xtea_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_low;
	logic [31:0] result_high;

	modport source (output valid, output result_low, output result_high, input ready);
	modport sink (input valid, input result_low, input result_high, output ready);
endinterface
`default_nettype wire

// File: rtl/xtea_half_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One Feistel half-round followed by its pipeline register.
// ----------------------------------------------------------------------------
module xtea_half_round (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  xtea_pkg::word_t  sum_enc,
	input  xtea_pkg::word_t  sum_dec,
	input  logic             odd,
	input  xtea_pkg::key_t   key,
	input  xtea_pkg::stage_t din,
	output xtea_pkg::stage_t dout
);
	import xtea_pkg::*;

	logic                 dec;
	logic                 upd_low;
	word_t                sum;
	word_t                src;
	word_t                dst;
	word_t                f;
	word_t                nxt;
	logic [KEY_IDX_W-1:0] ksel;

	logic  valid_s1;
	logic  op_s1;
	word_t lo_s1;
	word_t hi_s1;

	// encrypt: even stages update v0, odd stages v1; decrypt the other way round
	always_comb begin
		dec     = (din.op == OP_DECRYPT);
		upd_low = dec ? odd : ~odd;
		sum     = dec ? sum_dec : sum_enc;
		ksel    = upd_low ? sum[1:0] : sum[12:11];
		src     = upd_low ? din.hi : din.lo;
		dst     = upd_low ? din.lo : din.hi;
		f       = mix(src) ^ (sum + key[ksel]);
		nxt     = dec ? (dst - f) : (dst + f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= din.op;
			lo_s1 <= upd_low ? nxt : din.lo;
			hi_s1 <= upd_low ? din.hi : nxt;
		end
	end

	assign dout = '{valid: valid_s1, op: op_s1, lo: lo_s1, hi: hi_s1};

endmodule
`default_nettype wire

// File: rtl/xtea_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA output buffer
// Two-entry queue between the pipeline tail and the result port.
// ----------------------------------------------------------------------------
module xtea_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  xtea_pkg::res_t      din,
	input  logic                pop,
	output xtea_pkg::res_t      dout,
	output xtea_pkg::buf_stat_t stat
);
	import xtea_pkg::*;

	res_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	assign dout       = ent_q[rd_ptr_q];
	assign stat.valid = (count_q != 2'd0);
	// registered only: space follows count_q, with no combinational path from the port's ready
	assign stat.space = (count_q != 2'd2);

endmodule
`default_nettype wire

// File: rtl/xtea_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA block cipher
// Fully unrolled XTEA encrypt/decrypt pipeline, one 64-bit block per cycle unless res stalls.
// ----------------------------------------------------------------------------
// Each beat on blk carries one 64-bit block (block_low = v0, block_high = v1)
// and a direction bit (0 encrypt, 1 decrypt); each beat on res carries the
// processed block. Throughput is one block per clock while res keeps up:
// every half-round of the cipher has its own pipeline stage, so ROUND_COUNT
// rounds unroll into 2*ROUND_COUNT stages (64 with the default of 32). A
// block passes through those stages and then the output buffer before its
// result is visible on res. Blocks of both directions can be mixed freely
// back to back. The 128-bit key sits in four 32-bit registers written through
// cfg_we/cfg_index/cfg_data (reset to zero); write them only while no block is
// in flight. When res stalls, the whole pipeline freezes as soon as the
// two-entry output buffer fills; blk.ready comes straight from a register.
// ----------------------------------------------------------------------------
module xtea_block_cipher (
	input  logic                           clk,
	input  logic                           arst_n,
	xtea_blk_if.sink                       blk,
	xtea_res_if.source                     res,
	input  logic                           cfg_we,
	input  logic [xtea_pkg::KEY_IDX_W-1:0] cfg_index,
	input  xtea_pkg::word_t                cfg_data
);
	import xtea_pkg::*;

	key_t                   key_q;
	stage_t                 pipe [STAGE_COUNT+1];
	logic [STAGE_COUNT-1:0] vld_vec;
	logic                   en;
	res_t                   buf_din;
	res_t                   buf_dout;
	buf_stat_t              buf_stat;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	// global advance: stages move whenever the buffer has a free slot
	assign en        = buf_stat.space;
	assign blk.ready = en;

	assign pipe[0] = '{valid: blk.valid, op: blk.operation,
		lo: blk.block_low, hi: blk.block_high};

	for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_stage
		xtea_half_round u_hr (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.sum_enc (stage_sum_enc(g)),
			.sum_dec (stage_sum_dec(g)),
			.odd     (1'(g & 1)),
			.key     (key_q),
			.din     (pipe[g]),
			.dout    (pipe[g+1])
		);
		assign vld_vec[g] = pipe[g+1].valid;
	end

	assign buf_din = '{lo: pipe[STAGE_COUNT].lo, hi: pipe[STAGE_COUNT].hi};

	xtea_out_buf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (en && pipe[STAGE_COUNT].valid),
		.din    (buf_din),
		.pop    (res.valid && res.ready),
		.dout   (buf_dout),
		.stat   (buf_stat)
	);

	assign res.valid       = buf_stat.valid;
	assign res.result_low  = buf_dout.lo;
	assign res.result_high = buf_dout.hi;

	// a frozen pipeline keeps every beat in place
	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_vec))
		else $error("pipeline valid bits moved while frozen");

	// a full buffer always presents a result
	a_full_shows: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> res.valid)
		else $error("buffer full but no result offered");

	// a full buffer only drains through the port
	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && !res.ready) |=> !en)
		else $error("buffer left full state without a pop");

endmodule
`default_nettype wire
